>>> rtl/dqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Request codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell; at most one bit set
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                         Dir  Transfer when
// -------  --------------------------------------------  ---  ------------------------
// in       in_valid/in_ready, in_kind, in_value          in   in_valid & in_ready
// out      out_valid/out_ready, out_popped_value,        out  out_valid & out_ready
//          out_status, out_is_empty, out_is_full,
//          out_front_value, out_rear_value, out_entry_count
//
// The transfer edge shifts the cell row and captures the popped word and status; once the
// output is free the result registers load, with the rear word from a combinational tap OR tree.
// A new request is accepted only after the result registers have loaded the previous one.
// The result register is separate, so one request can be taken while a result waits.
// Reset (rst_n low, synchronous) empties the row; stored words need no clearing.

module double_ended_queue_core
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [KIND_W-1:0]          in_kind,
  input  wire logic signed [FIELD_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [FIELD_W-1:0]       out_popped_value,
  output logic [STATUS_W-1:0]             out_status,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  output logic signed [FIELD_W-1:0]       out_front_value,
  output logic signed [FIELD_W-1:0]       out_rear_value,
  output logic [CNT_W-1:0]                out_entry_count
);

  localparam int unsigned STORE_W = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int unsigned LEAVES  = 1 << $clog2(DEPTH);

  // Cell row
  logic [STORE_W-1:0] cell_data [DEPTH];
  logic [STORE_W-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [STORE_W-1:0] ins_word;
  cell_ctl_t          ctl;

  // Control and result registers
  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STORE_W-1:0] popped_r, popped_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STORE_W-1:0] out_popped_r, out_front_r, out_rear_r;
  status_t            out_status_r;
  logic               out_empty_r, out_full_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               in_xfer, load_out, is_full, is_empty;
  logic [STORE_W-1:0] rear_word, front_word;
  logic [STORE_W-1:0] tree [1:2*LEAVES-1];
  kind_t              kind;

  assign ins_word = in_value[STORE_W-1:0];
  assign kind     = kind_t'(in_kind);
  assign in_ready = ~busy_r;
  assign in_xfer  = in_valid & in_ready;
  assign load_out = busy_r & (~out_valid_r | out_ready);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Row of cells, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [STORE_W-1:0] l_data, r_data;
    logic               l_valid, r_valid;
    if (i == 0) begin : g_first
      assign l_data  = ins_word;
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end
    dqe_cell #(
      .WIDTH(STORE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_data   (ins_word),
      .left_data  (l_data),
      .left_valid (l_valid),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .tail_tap   (cell_tap[i])
    );
  end

  // OR tree over the taps; only the last occupied cell drives a non-zero tap
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < DEPTH) begin : g_used
      assign tree[LEAVES+k] = cell_tap[k];
    end else begin : g_pad
      assign tree[LEAVES+k] = '0;
    end
  end
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    assign tree[n] = tree[2*n] | tree[2*n+1];
  end
  assign rear_word  = tree[1];
  assign front_word = cell_valid[0] ? cell_data[0] : '0;

  // Request decode, popped word capture and count update
  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    busy_nxt   = busy_r;
    if (load_out) begin
      busy_nxt = 1'b0;
    end
    if (in_xfer) begin
      busy_nxt   = 1'b1;
      popped_nxt = '0;
      status_nxt = ST_OK;
      unique case (kind) inside
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            ctl.push_front = (kind == KIND_PUSH_FRONT);
            ctl.push_rear  = (kind == KIND_PUSH_REAR);
            count_nxt      = count_r + CNT_W'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (is_empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            ctl.pop_front = (kind == KIND_POP_FRONT);
            ctl.pop_rear  = (kind == KIND_POP_REAR);
            popped_nxt    = (kind == KIND_POP_FRONT) ? cell_data[0] : rear_word;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    if (load_out) begin
      out_popped_r <= popped_r;
      out_status_r <= status_r;
      out_empty_r  <= is_empty;
      out_full_r   <= is_full;
      out_front_r  <= front_word;
      out_rear_r   <= rear_word;
      out_count_r  <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = FIELD_W'(out_popped_r);
  assign out_status       = out_status_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;
  assign out_front_value  = FIELD_W'(out_front_r);
  assign out_rear_value   = FIELD_W'(out_rear_r);
  assign out_entry_count  = out_count_r;

  // Occupied cells form an unbroken run from the front
  logic valid_contig;
  assign valid_contig = &(~cell_valid[DEPTH-1:1] | cell_valid[DEPTH-2:0]);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("entry count disagrees with occupied cells");

  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    valid_contig)
    else $error("gap in occupied cells");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_is_full)
    else $error("overflow reported on a deque that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_is_empty && out_popped_value == '0)
    else $error("underflow reported on a deque that is not empty");

endmodule

`default_nettype wire

>>> rtl/dqe_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dqe_cell
  import dqe_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [WIDTH-1:0] ins_data,
  input  wire logic [WIDTH-1:0] left_data,
  input  wire logic             left_valid,
  input  wire logic [WIDTH-1:0] right_data,
  input  wire logic             right_valid,
  output logic      [WIDTH-1:0] data,
  output logic                  valid,
  output logic      [WIDTH-1:0] tail_tap
);

  logic [WIDTH-1:0] data_r, data_nxt;
  logic             valid_r, valid_nxt;
  logic             is_last;

  // Last occupied cell of the row holds the rear entry
  assign is_last = valid_r & ~right_valid;

  // Next contents from own state and the two neighbours
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.push_front) begin
      // whole row moves one place towards the rear
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.push_rear) begin
      // first free cell takes the new word
      if (!valid_r && left_valid) begin
        data_nxt  = ins_data;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_front) begin
      // whole row moves one place towards the front
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.pop_rear) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign valid    = valid_r;
  assign tail_tap = is_last ? data_r : '0;

endmodule

`default_nettype wire
